>>> hw/rtl/cft_pkg.sv
// Shared types, codes and the parse transition table of the CSV field tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package cft_pkg;

  typedef logic [2:0] state_t;
  typedef logic [2:0] cls_t;
  typedef logic [2:0] go_t;
  typedef logic [1:0] kind_t;

  // Parse states.
  localparam state_t ST_UNQUOTED   = 3'd0;
  localparam state_t ST_FIELD_END  = 3'd1;
  localparam state_t ST_QUOTE_OPEN = 3'd2;
  localparam state_t ST_QUOTED     = 3'd3;
  localparam state_t ST_QUOTE_EXIT = 3'd4;

  // Transition outcomes beyond the plain states.
  localparam go_t GO_ROW_END   = 3'd5;
  localparam go_t GO_QUOTE_EOF = 3'd6;

  // Character classes.
  localparam cls_t CLS_SEP   = 3'd0;
  localparam cls_t CLS_QUOTE = 3'd1;
  localparam cls_t CLS_NL    = 3'd2;
  localparam cls_t CLS_OTHER = 3'd3;
  localparam cls_t CLS_EOF   = 3'd4;

  localparam int NUM_STATES  = 5;
  localparam int NUM_CLASSES = 5;

  // Event kinds on the result channel.
  localparam kind_t EV_DATA  = 2'd0;
  localparam kind_t EV_FIELD = 2'd1;
  localparam kind_t EV_ROW   = 2'd2;
  localparam kind_t EV_QERR  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_QUOTE     = 2'd1;
  localparam logic [1:0] REG_NEWLINE   = 2'd2;

  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] NEWLINE_RESET   = 8'd10;

  // Rows are the current state, columns the character class.
  localparam go_t NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
    '{ST_FIELD_END, ST_QUOTE_OPEN, GO_ROW_END, ST_UNQUOTED, GO_ROW_END},
    '{ST_FIELD_END, ST_QUOTE_OPEN, GO_ROW_END, ST_UNQUOTED, GO_ROW_END},
    '{ST_QUOTED, ST_QUOTE_EXIT, ST_QUOTED, ST_QUOTED, GO_QUOTE_EOF},
    '{ST_QUOTED, ST_QUOTE_EXIT, ST_QUOTED, ST_QUOTED, GO_QUOTE_EOF},
    '{ST_FIELD_END, ST_QUOTED, GO_ROW_END, ST_UNQUOTED, GO_ROW_END}
  };

  // Outcome of one parse step.
  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] data;
    state_t     state_next;
    logic       row_started_next;
  } step_t;

endpackage
`default_nettype wire

>>> hw/rtl/cft_classify.sv
// Sorts one input byte into separator, quote, newline, other or end of input.
`timescale 1ns / 1ps
`default_nettype none
module cft_classify
  import cft_pkg::*;
(
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  input  wire logic [7:0] separator_char,
  input  wire logic [7:0] quote_char,
  input  wire logic [7:0] newline_char,
  output cls_t            cls
);

  // Separator wins over quote, and quote over newline, when they are equal.
  always_comb begin
    if (end_of_input) begin
      cls = CLS_EOF;
    end else if (in_byte == separator_char) begin
      cls = CLS_SEP;
    end else if (in_byte == quote_char) begin
      cls = CLS_QUOTE;
    end else if (in_byte == newline_char) begin
      cls = CLS_NL;
    end else begin
      cls = CLS_OTHER;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/cft_step.sv
// One step of the parse table: next state and the event that it emits.
`timescale 1ns / 1ps
`default_nettype none
module cft_step
  import cft_pkg::*;
(
  input  wire state_t     parse_state,
  input  wire logic       row_started,
  input  wire cls_t       cls,
  input  wire logic [7:0] in_byte,
  output step_t           step
);

  state_t cur;
  go_t    go;

  always_comb begin
    cur = (parse_state > ST_QUOTE_EXIT) ? ST_UNQUOTED : parse_state;
    go  = NEXT_TAB[cur][cls];

    step.emit             = 1'b0;
    step.kind             = EV_DATA;
    step.data             = 8'd0;
    step.state_next       = parse_state;
    step.row_started_next = row_started;

    if ((cls == CLS_EOF) && !row_started) begin
      // End of input on an empty row changes nothing.
      step.emit = 1'b0;
    end else begin
      step.row_started_next = 1'b1;
      case (go)
        GO_ROW_END, GO_QUOTE_EOF: begin
          step.emit             = 1'b1;
          step.kind             = (go == GO_ROW_END) ? EV_ROW : EV_QERR;
          step.state_next       = ST_UNQUOTED;
          step.row_started_next = 1'b0;
        end
        ST_UNQUOTED, ST_QUOTED: begin
          step.emit       = 1'b1;
          step.kind       = EV_DATA;
          step.data       = in_byte;
          step.state_next = go;
        end
        ST_FIELD_END: begin
          step.emit       = 1'b1;
          step.kind       = EV_FIELD;
          step.state_next = go;
        end
        ST_QUOTE_OPEN, ST_QUOTE_EXIT: begin
          step.state_next = go;
        end
        default: begin
          step.state_next = ST_UNQUOTED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/csv_field_tokenizer_core.sv
// Top level of the streaming CSV field tokenizer: registers, handshakes and parse state.
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  ---------------------------
//  byte      in         byte_valid / byte_stall   in_byte[7:0], end_of_input
//  event     out        event_valid / event_stall event_kind[1:0], out_byte[7:0]
//  cfg       in         cfg_we (no wait)          cfg_index[1:0], cfg_data[7:0]
//
// An accepted byte lands in an input register, is classified and stepped
// through the parse table combinationally, and its event is captured in the
// result register. One byte is taken every cycle while the byte channel does
// not stall; the only loop is the parse state register and its step logic.
// Reset clears the parse state, both valid flags and restores the default
// separator, quote and newline characters.
// A stall on the event channel holds the result register, and the byte
// channel stalls only while the input register is full and cannot move on.
`timescale 1ns / 1ps
`default_nettype none
module csv_field_tokenizer_core
  import cft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            event_valid,
  input  wire logic       event_stall,
  output kind_t           event_kind,
  output logic [7:0]      out_byte
);

  // Configuration registers.
  logic [7:0] separator_char;
  logic [7:0] quote_char;
  logic [7:0] newline_char;

  // Input register.
  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eof;

  // Parse state.
  state_t parse_state;
  logic   row_started;

  cls_t  cls;
  step_t step;
  logic  advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_char <= SEPARATOR_RESET;
      quote_char     <= QUOTE_RESET;
      newline_char   <= NEWLINE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEPARATOR: separator_char <= cfg_data;
        REG_QUOTE:     quote_char     <= cfg_data;
        REG_NEWLINE:   newline_char   <= cfg_data;
        default:       ;
      endcase
    end
  end

  cft_classify u_classify (
    .in_byte        (held_byte),
    .end_of_input   (held_eof),
    .separator_char (separator_char),
    .quote_char     (quote_char),
    .newline_char   (newline_char),
    .cls            (cls)
  );

  cft_step u_step (
    .parse_state (parse_state),
    .row_started (row_started),
    .cls         (cls),
    .in_byte     (held_byte),
    .step        (step)
  );

  // The held item moves on whenever the result register is free or being
  // drained this cycle; items that emit nothing move on as well.
  assign advance    = !event_valid || !event_stall;
  assign byte_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      held_byte <= in_byte;
      held_eof  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_UNQUOTED;
      row_started <= 1'b0;
    end else if (held_valid && advance) begin
      parse_state <= step.state_next;
      row_started <= step.row_started_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= held_valid && step.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid && step.emit) begin
      event_kind <= step.kind;
      out_byte   <= step.data;
    end
  end

  // A row that has consumed nothing is always in the unquoted start state.
  a_idle_row_start : assert property (@(posedge clk) disable iff (rst)
    !row_started |-> parse_state == ST_UNQUOTED)
    else $error("row not started but parse state left the start state");

  a_state_range : assert property (@(posedge clk) disable iff (rst)
    parse_state <= ST_QUOTE_EXIT)
    else $error("parse state holds an unused code");

  a_byte_zero : assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind != EV_DATA |-> out_byte == 8'd0)
    else $error("non-data event carries a byte");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> held_valid && event_valid)
    else $error("byte channel stalled while the pipeline can move");

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for the streaming CSV field tokenizer core.
`timescale 1ns / 1ps
module tb_top;
  import cft_pkg::*;

  // One byte transfer as the sender sees it.
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
  } byte_item_t;

  // One tokenizer event as the receiver expects it.
  typedef struct {
    kind_t      kind;
    logic [7:0] data;
  } token_t;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Bytes that open or close a quote produce no event at all, so the settle
  // window after the last expected event has to cover the whole pipe.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED = 30;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SEPARATOR;
  logic [7:0] cfg_data = 8'h00;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_input = 1'b0;
  logic       event_valid;
  logic       event_stall = 1'b0;
  kind_t      event_kind;
  logic [7:0] out_byte;

  csv_field_tokenizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_kind   (event_kind),
    .out_byte     (out_byte)
  );

  // Work still to be sent, and the events the tokenizer owes us.
  byte_item_t  byte_queue[$];
  token_t      expected_tokens[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_accepted = 0;
  int unsigned errors = 0;
  int unsigned settings_used = 1;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};

  // When set, neither side idles: transfers go back to back.
  logic        steady = 1'b0;

  // Our own copy of the character registers and of the parse position.
  logic [7:0]  sep_char = SEPARATOR_RESET;
  logic [7:0]  quote_char = QUOTE_RESET;
  logic [7:0]  nl_char = NEWLINE_RESET;
  state_t      parse_pos = ST_UNQUOTED;
  logic        row_open = 1'b0;

  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  byte_item_t  next_item;
  token_t      want;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop: far beyond the slowest correct run with every gap and stall
  // at its longest.
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    errors++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Predicts the event, if any, that one accepted transfer causes, and
  // advances the parse position. Class priority is separator, then quote,
  // then newline, so overlapping characters resolve the same way the
  // hardware must resolve them.
  function automatic void predict_token(input logic [7:0] ch, input logic eoi);
    token_t tok;
    logic   hit;
    logic   in_quotes;
    cls_t   cls;

    hit = 1'b0;
    tok.kind = EV_DATA;
    tok.data = 8'h00;
    in_quotes = (parse_pos == ST_QUOTE_OPEN) || (parse_pos == ST_QUOTED);

    if (eoi) begin
      // An end mark on a row that has not consumed a byte is silent.
      if (row_open) begin
        hit = 1'b1;
        tok.kind = in_quotes ? EV_QERR : EV_ROW;
        parse_pos = ST_UNQUOTED;
        row_open = 1'b0;
      end
    end else begin
      row_open = 1'b1;
      if (ch == sep_char) cls = CLS_SEP;
      else if (ch == quote_char) cls = CLS_QUOTE;
      else if (ch == nl_char) cls = CLS_NL;
      else cls = CLS_OTHER;

      if (in_quotes) begin
        // Inside quotes only the quote character matters; everything else,
        // separators and newlines included, is cell content.
        if (cls == CLS_QUOTE) begin
          parse_pos = ST_QUOTE_EXIT;
        end else begin
          parse_pos = ST_QUOTED;
          hit = 1'b1;
          tok.data = ch;
        end
      end else begin
        case (cls)
          CLS_SEP: begin
            parse_pos = ST_FIELD_END;
            hit = 1'b1;
            tok.kind = EV_FIELD;
          end
          CLS_QUOTE: begin
            // A quote right after a closing quote is the doubled form and
            // stands for one literal quote; anywhere else it opens quoting,
            // mid-field as well as at the start of a field.
            if (parse_pos == ST_QUOTE_EXIT) begin
              parse_pos = ST_QUOTED;
              hit = 1'b1;
              tok.data = ch;
            end else begin
              parse_pos = ST_QUOTE_OPEN;
            end
          end
          CLS_NL: begin
            parse_pos = ST_UNQUOTED;
            row_open = 1'b0;
            hit = 1'b1;
            tok.kind = EV_ROW;
          end
          default: begin
            parse_pos = ST_UNQUOTED;
            hit = 1'b1;
            tok.data = ch;
          end
        endcase
      end
    end

    if (hit) expected_tokens.push_back(tok);
  endfunction

  // Sender. A free slot is one with nothing offered or whose transfer
  // completes at this edge; only then may a new item go out, so a stalled
  // payload never moves. Valid is decided once per edge and, once raised,
  // is held until the transfer completes.
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        predict_token(in_byte, end_of_input);
        bytes_accepted++;
        send_gap = steady ? 0 : pick_gap();
      end
      if (!byte_valid || !byte_stall) begin
        if (send_gap != 0) begin
          send_gap--;
          byte_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          next_item = byte_queue.pop_front();
          byte_valid <= 1'b1;
          in_byte <= next_item.ch;
          end_of_input <= next_item.eoi;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each event transfer is matched against the oldest expectation,
  // field by field. Stalls come in random runs except in steady phases.
  always @(posedge clk) begin
    if (rst) begin
      event_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (event_valid && !event_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("event kind %0d byte %02h with nothing expected",
                                    event_kind, out_byte));
        end else begin
          want = expected_tokens.pop_front();
          if (event_kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, expected %0d",
                                      event_kind, want.kind));
          if (out_byte !== want.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h (kind %0d)",
                                      out_byte, want.data, want.kind));
          kind_seen[want.kind]++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        event_stall <= 1'b1;
      end else begin
        event_stall <= 1'b0;
        stall_left = steady ? 0 : pick_gap();
      end
    end
  end

  task automatic push_item(input logic [7:0] ch, input logic eoi);
    byte_item_t it;
    it.ch = ch;
    it.eoi = eoi;
    byte_queue.push_back(it);
    bytes_queued++;
  endtask

  // Any byte that is none of the three configured characters.
  function automatic logic [7:0] pick_other();
    logic [7:0] v;
    do begin
      v = 8'($urandom_range(255));
    end while (v == sep_char || v == quote_char || v == nl_char);
    return v;
  endfunction

  // Blocks until every queued item has been sent and every expected event has
  // come back, then lets the pipe run dry of silent items too.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (byte_queue.size() != 0 || bytes_accepted != bytes_queued ||
               expected_tokens.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write lands at the edge where cfg_we is high; the block is idle, so
  // updating our copy right away cannot skew any prediction.
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEPARATOR: sep_char = val;
      REG_QUOTE:     quote_char = val;
      REG_NEWLINE:   nl_char = val;
      default: ;
    endcase
  endtask

  // Random traffic, mostly well-formed rows: unquoted and quoted fields,
  // quoted content with doubled quotes, separators and newlines, rows ended
  // by a newline or an end mark. The rest is noise with stray end marks,
  // which also leaves quoted fields unterminated.
  task automatic queue_random(input int unsigned n);
    int unsigned target;
    int unsigned nf;
    int unsigned len;
    int unsigned r;
    target = bytes_queued + n;
    while (bytes_queued < target) begin
      if ($urandom_range(99) < 75) begin
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
          if (f != 0) push_item(sep_char, 1'b0);
          len = $urandom_range(0, 5);
          if ($urandom_range(99) < 40) begin
            push_item(quote_char, 1'b0);
            for (int k = 0; k < len; k++) begin
              r = $urandom_range(99);
              if (r < 15) begin
                push_item(quote_char, 1'b0);
                push_item(quote_char, 1'b0);
              end else if (r < 25) begin
                push_item(sep_char, 1'b0);
              end else if (r < 35) begin
                push_item(nl_char, 1'b0);
              end else begin
                push_item(pick_other(), 1'b0);
              end
            end
            if ($urandom_range(99) < 5) push_item(8'($urandom_range(255)), 1'b1);
            else push_item(quote_char, 1'b0);
          end else begin
            for (int k = 0; k < len; k++) push_item(pick_other(), 1'b0);
          end
        end
        if ($urandom_range(99) < 85) begin
          push_item(nl_char, 1'b0);
        end else begin
          push_item(8'($urandom_range(255)), 1'b1);
          if ($urandom_range(1) == 1) push_item(8'($urandom_range(255)), 1'b1);
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 10) push_item(8'($urandom_range(255)), 1'b1);
          else if (r < 25) push_item(sep_char, 1'b0);
          else if (r < 40) push_item(quote_char, 1'b0);
          else if (r < 55) push_item(nl_char, 1'b0);
          else push_item(8'($urandom_range(255)), 1'b0);
        end
      end
    end
  endtask

  // Drain, retune all three characters (plus a write to the empty index),
  // then run random traffic. Draining first is also where the sender holds
  // off until every expected event is back.
  task automatic run_phase(input logic [7:0] sep, input logic [7:0] quo,
                           input logic [7:0] nl, input logic no_idle,
                           input int unsigned n);
    wait_drained();
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_QUOTE, quo);
    write_reg(REG_NEWLINE, nl);
    write_reg(REG_UNUSED, 8'($urandom_range(255)));
    steady = no_idle;
    settings_used++;
    queue_random(n);
  endtask

  initial begin
    wait (rst == 1'b0);
    @(posedge clk);

    // Directed walk through the table with the reset characters.
    push_item(8'h55, 1'b1);              // end mark on an empty row: silent
    push_item(8'h00, 1'b0);              // lowest plain byte
    push_item(8'hFF, 1'b0);              // highest plain byte
    push_item(SEPARATOR_RESET, 1'b0);    // end of field
    push_item(QUOTE_RESET, 1'b0);        // open quote
    push_item(SEPARATOR_RESET, 1'b0);    // separator as quoted content
    push_item(NEWLINE_RESET, 1'b0);      // newline as quoted content
    push_item(QUOTE_RESET, 1'b0);        // close quote
    push_item(QUOTE_RESET, 1'b0);        // doubled quote gives one quote byte
    push_item(QUOTE_RESET, 1'b0);        // close again
    push_item(NEWLINE_RESET, 1'b0);      // end of row right after a quote
    push_item("q", 1'b0);
    push_item(QUOTE_RESET, 1'b0);        // quote in mid-field opens quoting
    push_item("z", 1'b0);
    push_item(8'hAA, 1'b1);              // stream ends inside quotes
    push_item(8'h00, 1'b1);              // empty row again: silent
    push_item(SEPARATOR_RESET, 1'b0);
    push_item(8'hFF, 1'b1);              // end mark closes a started row
    push_item(QUOTE_RESET, 1'b0);
    push_item(8'h01, 1'b1);              // end right after an opening quote
    push_item(QUOTE_RESET, 1'b0);        // empty quoted field ...
    push_item(QUOTE_RESET, 1'b0);
    push_item(SEPARATOR_RESET, 1'b0);    // ... then a separator
    push_item(QUOTE_RESET, 1'b0);
    push_item(QUOTE_RESET, 1'b0);
    push_item("x", 1'b0);                // plain byte after a closing quote
    push_item(NEWLINE_RESET, 1'b0);
    queue_random(140);

    // Extremes, then overlapping characters where priority decides the class.
    run_phase(8'h00, 8'hFF, 8'h80, 1'b1, 140);
    run_phase(8'hFF, 8'h00, 8'hFF, 1'b0, 140);  // newline hidden by separator
    run_phase(8'h07, 8'h07, 8'h07, 1'b0, 100);  // all three the same
    run_phase(8'h09, 8'h0D, 8'h0D, 1'b0, 100);  // newline hidden by quote
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'b0, 140);
    run_phase(SEPARATOR_RESET, QUOTE_RESET, NEWLINE_RESET, 1'b0, 140);
    wait_drained();

    $display("Covered %0d byte transfers under %0d character settings.",
             bytes_accepted, settings_used);
    $display("Events: %0d data, %0d field ends, %0d row ends, %0d open-quote errors.",
             kind_seen[EV_DATA], kind_seen[EV_FIELD], kind_seen[EV_ROW], kind_seen[EV_QERR]);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
